[design/assert_macros.svh]
// assertion macros shared by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with synchronous reset disable
`define BTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bts_pkg.sv]
// package with widths, codes and types of the bilinear texture sampler
package bts_pkg;

   localparam int TEXEL_ADDR_W = 16;
   localparam int DIM_W        = 9;
   localparam int CHAN_W       = 8;
   localparam int TEXEL_W      = 3 * CHAN_W;
   localparam int FRAC_BITS    = 8;
   localparam int FRAC_W       = 16;
   localparam int COORD_W      = 32;
   localparam int OUT_W        = 16;
   localparam int BIGU_W       = FRAC_W + DIM_W;
   localparam int BIGV_W       = FRAC_W + 1 + DIM_W;
   localparam int REQ_TDATA_W  = TEXEL_ADDR_W + TEXEL_W + 2 * COORD_W;
   localparam int RSP_TDATA_W  = 3 * OUT_W;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [DIM_W-1:0] MAX_DIM = 9'd256;

   // command codes carried on tuser
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_TEX_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEX_HEIGHT = 3'd4;

   typedef logic [TEXEL_W-1:0]      texel_type;
   typedef logic [TEXEL_ADDR_W-1:0] taddr_type;
   typedef logic [DIM_W-1:0]        dim_type;
   typedef logic [FRAC_BITS-1:0]    frac_type;

   // control that travels with each pipeline stage
   typedef struct packed {
      logic valid;
      logic cmd;
   } ctl_type;

endpackage

[design/bts_addr.sv]
// coordinate scaling, corner clamping and texel address generation
`include "assert_macros.svh"
module bts_addr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  bts_pkg::ctl_type                    in_ctl,
   input  bts_pkg::taddr_type                  in_waddr,
   input  bts_pkg::texel_type                  in_wdata,
   input  logic signed [bts_pkg::COORD_W-1:0]  coord_u,
   input  logic signed [bts_pkg::COORD_W-1:0]  coord_v,
   input  bts_pkg::dim_type                    tex_width,
   input  bts_pkg::dim_type                    tex_height,
   output bts_pkg::ctl_type                    out_ctl,
   output bts_pkg::taddr_type [3:0]            out_addr,
   output bts_pkg::frac_type                   out_s,
   output bts_pkg::frac_type                   out_t,
   output bts_pkg::taddr_type                  out_waddr,
   output bts_pkg::texel_type                  out_wdata
);
   import bts_pkg::*;

   dim_type             w, h;
   ctl_type             ctl1_ff, ctl2_ff;
   logic [BIGU_W-1:0]   bigu_ff, bigu_in;
   logic [BIGV_W-1:0]   bigv_ff, bigv_in;
   taddr_type           waddr1_ff, waddr2_ff;
   texel_type           wdata1_ff, wdata2_ff;
   dim_type             iu, iv, x1, y0, y1;
   taddr_type [3:0]     addr_ff, addr_in;
   frac_type            s_ff, t_ff;
   logic [FRAC_W:0]     vf;

   // effective dimensions: zero acts as one, large values saturate
   always_comb begin
      w = (tex_width == '0) ? 9'd1 : ((tex_width > MAX_DIM) ? MAX_DIM : tex_width);
      h = (tex_height == '0) ? 9'd1 : ((tex_height > MAX_DIM) ? MAX_DIM : tex_height);
   end

   // stage 1: wrap to fraction, flip v, scale by dimensions
   always_comb begin
      vf      = 17'h10000 - {1'b0, coord_v[FRAC_W-1:0]};
      bigu_in = BIGU_W'(coord_u[FRAC_W-1:0] * w);
      bigv_in = BIGV_W'(vf * h);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (en) begin
         ctl1_ff <= in_ctl;
      end
      if (en) begin
         bigu_ff   <= bigu_in;
         bigv_ff   <= bigv_in;
         waddr1_ff <= in_waddr;
         wdata1_ff <= in_wdata;
      end
   end

   // stage 2: clamp corners to the texture and form row-major addresses
   always_comb begin
      iu = DIM_W'(bigu_ff[BIGU_W-1:FRAC_W]);
      iv = DIM_W'(bigv_ff[BIGV_W-1:FRAC_W]);
      x1 = (iu + 9'd1 > w - 9'd1) ? w - 9'd1 : iu + 9'd1;
      y0 = (iv > h - 9'd1) ? h - 9'd1 : iv;
      y1 = (iv + 9'd1 > h - 9'd1) ? h - 9'd1 : iv + 9'd1;
      addr_in[0] = TEXEL_ADDR_W'(y0 * w + iu);
      addr_in[1] = TEXEL_ADDR_W'(y0 * w + x1);
      addr_in[2] = TEXEL_ADDR_W'(y1 * w + iu);
      addr_in[3] = TEXEL_ADDR_W'(y1 * w + x1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else if (en) begin
         ctl2_ff <= ctl1_ff;
      end
      if (en) begin
         addr_ff   <= addr_in;
         s_ff      <= bigu_ff[FRAC_W-1:FRAC_W-FRAC_BITS];
         t_ff      <= bigv_ff[FRAC_W-1:FRAC_W-FRAC_BITS];
         waddr2_ff <= waddr1_ff;
         wdata2_ff <= wdata1_ff;
      end
   end

   assign out_ctl   = ctl2_ff;
   assign out_addr  = addr_ff;
   assign out_s     = s_ff;
   assign out_t     = t_ff;
   assign out_waddr = waddr2_ff;
   assign out_wdata = wdata2_ff;

   // lower row never lies above the upper one
   `BTS_ASSERT(a_row_order, clock, reset, (ctl2_ff.valid && ctl2_ff.cmd == CMD_SAMPLE) |-> (addr_ff[2] >= addr_ff[0]), "lower row address below upper row")

endmodule

[design/bts_fetch.sv]
// texel memory, four copies so that the four corners are read at once
module bts_fetch (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  bts_pkg::ctl_type              in_ctl,
   input  bts_pkg::taddr_type [3:0]      in_addr,
   input  bts_pkg::frac_type             in_s,
   input  bts_pkg::frac_type             in_t,
   input  bts_pkg::taddr_type            in_waddr,
   input  bts_pkg::texel_type            in_wdata,
   output bts_pkg::ctl_type              out_ctl,
   output bts_pkg::texel_type [3:0]      out_texel,
   output bts_pkg::frac_type             out_s,
   output bts_pkg::frac_type             out_t
);
   import bts_pkg::*;

   localparam int DEPTH = 1 << TEXEL_ADDR_W;

   texel_type       mem0 [DEPTH];
   texel_type       mem1 [DEPTH];
   texel_type       mem2 [DEPTH];
   texel_type       mem3 [DEPTH];
   texel_type [3:0] rd_ff;
   ctl_type         ctl_ff;
   frac_type        s_ff, t_ff;
   logic            wr_en;

   assign wr_en = en && in_ctl.valid && (in_ctl.cmd == CMD_WRITE);

   // every copy takes each write; each copy serves one corner
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem0[in_waddr] <= in_wdata;
         mem1[in_waddr] <= in_wdata;
         mem2[in_waddr] <= in_wdata;
         mem3[in_waddr] <= in_wdata;
      end
      if (en) begin
         rd_ff[0] <= mem0[in_addr[0]];
         rd_ff[1] <= mem1[in_addr[1]];
         rd_ff[2] <= mem2[in_addr[2]];
         rd_ff[3] <= mem3[in_addr[3]];
         s_ff     <= in_s;
         t_ff     <= in_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= in_ctl;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_texel = rd_ff;
   assign out_s     = s_ff;
   assign out_t     = t_ff;

endmodule

[design/bts_blend.sv]
// horizontal then vertical blend of the four corner texels
`include "assert_macros.svh"
module bts_blend (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  bts_pkg::ctl_type                        in_ctl,
   input  bts_pkg::texel_type [3:0]                in_texel,
   input  bts_pkg::frac_type                       in_s,
   input  bts_pkg::frac_type                       in_t,
   output logic                                    out_valid,
   output logic [2:0][bts_pkg::OUT_W-1:0]          out_chan
);
   import bts_pkg::*;

   localparam logic [FRAC_BITS:0] ONE = 9'd256;

   logic                         valid4_ff, valid5_ff;
   logic [2:0][OUT_W-1:0]        lo_ff, hi_ff, lo_in, hi_in, res_ff, res_in;
   logic [2:0][OUT_W+FRAC_BITS-1:0] sum;
   frac_type                     t_ff;
   logic [FRAC_BITS:0]           ns, nt;
   logic [2:0][CHAN_W-1:0]       c00, c10, c01, c11;

   // stage 4: blend along u for both rows
   always_comb begin
      ns = ONE - {1'b0, in_s};
      for (int k = 0; k < 3; k++) begin
         c00[k]   = in_texel[0][TEXEL_W-1-CHAN_W*k -: CHAN_W];
         c10[k]   = in_texel[1][TEXEL_W-1-CHAN_W*k -: CHAN_W];
         c01[k]   = in_texel[2][TEXEL_W-1-CHAN_W*k -: CHAN_W];
         c11[k]   = in_texel[3][TEXEL_W-1-CHAN_W*k -: CHAN_W];
         lo_in[k] = OUT_W'(ns * c00[k] + in_s * c10[k]);
         hi_in[k] = OUT_W'(ns * c01[k] + in_s * c11[k]);
      end
   end

   // stage 5: blend along v and drop the extra fraction bits
   always_comb begin
      nt = ONE - {1'b0, t_ff};
      for (int k = 0; k < 3; k++) begin
         sum[k]    = nt * lo_ff[k] + t_ff * hi_ff[k];
         res_in[k] = sum[k][2 * FRAC_BITS - 8 +: OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (en) begin
         valid4_ff <= in_ctl.valid && (in_ctl.cmd == CMD_SAMPLE);
         valid5_ff <= valid4_ff;
      end
      if (en) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         t_ff   <= in_t;
         res_ff <= res_in;
      end
   end

   assign out_valid = valid5_ff;
   assign out_chan  = res_ff;

   // partial blends never exceed full byte scale
   `BTS_ASSERT(a_lo_range, clock, reset, valid4_ff |-> (lo_ff[0] <= 16'hFF00 && hi_ff[0] <= 16'hFF00), "row blend out of range")
   // a sample in stage 4 reaches the output on the next advance
   `BTS_ASSERT(a_advance, clock, reset, (en && valid4_ff) |=> valid5_ff, "sample lost between blend stages")

endmodule

[design/bilinear_texture_sampler_top.sv]
// top level of the bilinear texture sampler with repeat addressing
// Usage:
//   req channel: tuser = cmd (0 write texel, 1 sample). tdata carries the
//   texel address, red, green, blue and the Q16.16 coordinates u and v.
//   A write stores one RGB texel and returns nothing; a sample returns one
//   rsp transaction with red, green and blue blended, in units of 1/256 of
//   a byte step.
//   csr port: tex_width at byte address 0, tex_height at 4; write only
//   while the block is idle.
// Timing:
//   one transaction accepted per cycle while rsp does not stall; rsp_tvalid
//   rises once it has passed the five register stages (scale, address,
//   memory read, row blend, column blend).
//   Four copies of the texel memory give the four corner reads per cycle.
// Reset:
//   clears the pipeline and sets both dimensions to 256; texel memory
//   contents stay undefined until written, no clearing pass.
// Stall:
//   while a result waits on rsp the whole pipeline holds and req_tready is
//   low; nothing is dropped or repeated.
module bilinear_texture_sampler_top
   import bts_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // req: tdata = texel_addr, in_red, in_green, in_blue, coord_u, coord_v
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_TDATA_W-1:0]       req_tdata,
   // req: tuser = cmd
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // rsp: tdata = out_red, out_green, out_blue
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   logic                     en;
   dim_type                  width_ff, height_ff;
   ctl_type                  in_ctl, a_ctl, f_ctl;
   taddr_type [3:0]          a_addr;
   frac_type                 a_s, a_t, f_s, f_t;
   taddr_type                a_waddr;
   texel_type                a_wdata, in_wdata;
   texel_type [3:0]          f_texel;
   logic [2:0][OUT_W-1:0]    chan;

   // pipeline advances whenever the output register is free or drained
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // register file
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MAX_DIM;
         height_ff <= MAX_DIM;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == CSR_TEX_WIDTH)  width_ff  <= csr_pwdata[DIM_W-1:0];
         if (csr_paddr == CSR_TEX_HEIGHT) height_ff <= csr_pwdata[DIM_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_TEX_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         CSR_TEX_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // unpack the request transaction
   assign in_ctl.valid = req_tvalid;
   assign in_ctl.cmd   = req_tuser;
   assign in_wdata     = {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]};

   bts_addr u_addr (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_ctl     (in_ctl),
      .in_waddr   (req_tdata[15:0]),
      .in_wdata   (in_wdata),
      .coord_u    (req_tdata[71:40]),
      .coord_v    (req_tdata[103:72]),
      .tex_width  (width_ff),
      .tex_height (height_ff),
      .out_ctl    (a_ctl),
      .out_addr   (a_addr),
      .out_s      (a_s),
      .out_t      (a_t),
      .out_waddr  (a_waddr),
      .out_wdata  (a_wdata)
   );

   bts_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (a_ctl),
      .in_addr   (a_addr),
      .in_s      (a_s),
      .in_t      (a_t),
      .in_waddr  (a_waddr),
      .in_wdata  (a_wdata),
      .out_ctl   (f_ctl),
      .out_texel (f_texel),
      .out_s     (f_s),
      .out_t     (f_t)
   );

   bts_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (f_ctl),
      .in_texel  (f_texel),
      .in_s      (f_s),
      .in_t      (f_t),
      .out_valid (rsp_tvalid),
      .out_chan  (chan)
   );

   // red in the low bits, then green, then blue
   assign rsp_tdata = {chan[2], chan[1], chan[0]};

endmodule
